// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/tte_pkg.sv
package tte_pkg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UNMARK,
        ST_PLAN,
        ST_MARK,
        ST_DISPATCH,
        ST_RUN_RD,
        ST_RUN_WR,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_COPY,
        OP_FILL,
        OP_XOR,
        OP_READ
    } op_kind_t;

    typedef enum logic [1:0] {
        CONT_PLAN,
        CONT_MARK,
        CONT_DONE
    } cont_t;

    typedef enum logic [4:0] {
        F_PUTC          = 5'd0,
        F_RAW           = 5'd1,
        F_SETC          = 5'd2,
        F_PUTXY         = 5'd3,
        F_GOTO          = 5'd4,
        F_SETX          = 5'd5,
        F_MOVEX         = 5'd6,
        F_MOVEY         = 5'd7,
        F_SOL           = 5'd8,
        F_CFWD          = 5'd9,
        F_CBACK         = 5'd10,
        F_LF            = 5'd11,
        F_LFWD          = 5'd12,
        F_LBACK         = 5'd13,
        F_SCROLL_UP     = 5'd14,
        F_SCROLL_DN     = 5'd15,
        F_INS_LINE      = 5'd16,
        F_DEL_LINE      = 5'd17,
        F_INS_CHAR      = 5'd18,
        F_DEL_CHAR      = 5'd19,
        F_ERASE         = 5'd20,
        F_ERASE_LINE    = 5'd21,
        F_CLRSCR        = 5'd22,
        F_CLRLINE       = 5'd23,
        F_CLREOL        = 5'd24,
        F_MARGINS       = 5'd25,
        F_RESET_MARGINS = 5'd26,
        F_REVERSE       = 5'd27,
        F_CURSOR        = 5'd28,
        F_INVERT        = 5'd29,
        F_READ          = 5'd30,
        F_NOP           = 5'd31
    } func_t;

    localparam logic [1:0] ERASE_TO_END    = 2'd0;
    localparam logic [1:0] ERASE_TO_CURSOR = 2'd1;
    localparam logic [1:0] ERASE_ALL       = 2'd2;

    localparam logic [7:0] REV_BIT = 8'h80;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

endpackage

// File: sv/tte_ram.sv
module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/text_terminal_cell_engine.sv
// Character-cell terminal engine. A command beat is taken at a rising edge where start is
// high and busy is low; every command gives exactly one status beat, shown for one cycle
// while done is high, and the receiver cannot hold it off. After reset the block sweeps
// the cell memory to zero, one cell per cycle (all COLS*ROWS cells, 2048 by default), with
// busy high. All cell work runs through one sequencer that issues operations on a memory
// with one read port and one write port: a copy or an invert reads, then writes each cell,
// and a fill only writes. With the cursor shown, lifting and redrawing its mark around a
// printed character each add a read, a write and a dispatch step. Busy drops in the cycle
// after the status beat. A scroll copies each moved cell of the scroll region, then fills
// the new line; a full-screen clear fills every cell.
module text_terminal_cell_engine import tte_pkg::*; #(
    parameter int COLS = 64,
    parameter int ROWS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    input  logic [4:0] func,
    input  logic [7:0] char_code,
    input  logic [7:0] col,
    input  logic [7:0] row,
    input  logic [7:0] amount,
    input  logic [7:0] length,
    input  logic [1:0] erase_mode,
    input  logic       enable,
    input  logic [7:0] top,
    input  logic [7:0] bottom,
    output logic [7:0] read_char,
    output logic [6:0] cursor_col,
    output logic [4:0] cursor_row,
    output logic       cursor_shown,
    output logic [4:0] region_top,
    output logic [4:0] bottom_margin,
    output logic       reverse_shown
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int CW    = $clog2(COLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int LW    = (CNTW > 8) ? CNTW : 8;

    localparam logic [CNTW-1:0] C_ZERO  = CNTW'(0);
    localparam logic [CNTW-1:0] C_ONE   = CNTW'(1);
    localparam logic [CNTW-1:0] C_TWO   = CNTW'(2);
    localparam logic [CNTW-1:0] C_COLS  = CNTW'(COLS);
    localparam logic [CNTW-1:0] C_CELLS = CNTW'(CELLS);

    // One memory operation: a run of cells walked up or down from src and dst.
    typedef struct packed {
        op_kind_t        kind;
        logic            desc;
        logic [AW-1:0]   src;
        logic [AW-1:0]   dst;
        logic [CNTW-1:0] cnt;
        logic [7:0]      data;
    } op_t;

    function automatic op_t mk_op(input op_kind_t kind, input logic desc,
                                  input logic [CNTW-1:0] src, input logic [CNTW-1:0] dst,
                                  input logic [CNTW-1:0] cnt, input logic [7:0] data);
        op_t o;
        o.kind = kind;
        o.desc = desc;
        o.src  = AW'(src);
        o.dst  = AW'(dst);
        o.cnt  = cnt;
        o.data = data;
        return o;
    endfunction

    function automatic logic [CNTW-1:0] row_base(input logic [RW-1:0] r);
        return CNTW'(r) * C_COLS;
    endfunction

    // Control and terminal state.
    state_t          state_reg, state_next;
    op_t             op_reg, op_next;
    op_t             opb_reg, opb_next;
    cont_t           cont_reg, cont_next;
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [RW-1:0]   top_reg, top_next;
    logic [RW-1:0]   bot_reg, bot_next;
    logic            rev_reg, rev_next;
    logic            curs_reg, curs_next;
    logic [7:0]      rdc_reg, rdc_next;
    logic [AW-1:0]   clr_reg, clr_next;

    // Command beat, held for the whole command.
    func_t           func_reg;
    logic [7:0]      ch_reg;
    logic [7:0]      colin_reg;
    logic [7:0]      rowin_reg;
    logic signed [7:0] amt_reg;
    logic [7:0]      len_reg;
    logic [1:0]      mode_reg;
    logic            en_reg;
    logic [7:0]      topin_reg;
    logic [7:0]      botin_reg;

    // Memory port.
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    // Planner signals.
    logic [CNTW-1:0] base, tbase, bbase, pos, curpos, xyb, rem, ecn;
    logic [CW-1:0]   ec;
    logic [7:0]      fb;
    logic            vis, in_xy, ld_scroll, op_live, accept;
    logic [RW-1:0]   ld_row;
    logic signed [9:0] sx, sy;
    logic signed [8:0] t_s, b_s;
    op_t             su_a, su_b, sd_a, sd_b, op_none, xor_cur;
    op_t             p_a, p_b;
    cont_t           p_cont;
    logic [CW-1:0]   p_col;
    logic [RW-1:0]   p_row, p_top, p_bot;
    logic            p_rev, p_curs;

    assign accept  = start && (state_reg == ST_IDLE);
    assign op_live = (op_reg.kind != OP_NONE) && (op_reg.cnt != C_ZERO);

    tte_ram #(
        .WIDTH(8),
        .DEPTH(CELLS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Common terms of the planner.
    always_comb
    begin
        base    = row_base(row_reg);
        tbase   = row_base(top_reg);
        bbase   = row_base(bot_reg);
        ec      = (col_reg >= CW'(COLS)) ? CW'(COLS - 1) : col_reg;
        ecn     = CNTW'(ec);
        pos     = base + ecn;
        curpos  = base + CNTW'(col_reg);
        fb      = rev_reg ? REV_BIT : 8'h00;
        vis     = curs_reg && (col_reg < CW'(COLS));
        in_xy   = !colin_reg[7] && (colin_reg < 8'(COLS)) &&
                  !rowin_reg[7] && (rowin_reg < 8'(ROWS));
        xyb     = row_base(RW'(rowin_reg)) + CNTW'(colin_reg);
        rem     = C_CELLS - xyb;
        ld_scroll = (row_reg >= bot_reg);
        ld_row  = ld_scroll ? bot_reg : row_reg + RW'(1);
        sx      = $signed(10'(col_reg)) + 10'(amt_reg);
        sy      = $signed(10'(row_reg)) + 10'(amt_reg);
        t_s     = topin_reg[7] ? 9'sd0 : $signed({1'b0, topin_reg});
        b_s     = (!botin_reg[7] && (botin_reg >= 8'(ROWS))) ? 9'(ROWS - 1)
                                                             : 9'($signed(botin_reg));
        op_none = mk_op(OP_NONE, 1'b0, C_ZERO, C_ZERO, C_ZERO, 8'h00);
        xor_cur = mk_op(OP_XOR, 1'b0, curpos, curpos, C_ONE, 8'h00);
        su_a    = mk_op(OP_COPY, 1'b0, tbase + C_COLS, tbase, bbase - tbase, 8'h00);
        su_b    = mk_op(OP_FILL, 1'b0, bbase, bbase, C_COLS, fb);
        sd_a    = mk_op(OP_COPY, 1'b1, bbase - C_ONE, bbase + C_COLS - C_ONE,
                        bbase - tbase, 8'h00);
        sd_b    = mk_op(OP_FILL, 1'b0, tbase, tbase, C_COLS, fb);
    end

    // Command planner: cursor, margin, reverse and cursor-shown updates plus up to two memory operations.
    always_comb
    begin
        p_a    = op_none;
        p_b    = op_none;
        p_cont = CONT_MARK;
        p_col  = col_reg;
        p_row  = row_reg;
        p_top  = top_reg;
        p_bot  = bot_reg;
        p_rev  = rev_reg;
        p_curs = curs_reg;
        unique case (func_reg)
            F_PUTC, F_RAW:
            begin
                if (col_reg >= CW'(COLS))
                begin
                    // A pending wrap moves to a new line first; then the command is planned again.
                    p_col  = '0;
                    p_row  = ld_row;
                    p_cont = CONT_PLAN;
                    if (ld_scroll)
                    begin
                        p_a = su_a;
                        p_b = su_b;
                    end
                end
                else if (func_reg == F_PUTC && ch_reg == CHAR_CR)
                begin
                    p_col = '0;
                end
                else if (func_reg == F_PUTC && ch_reg == CHAR_LF)
                begin
                    p_col = '0;
                    p_row = ld_row;
                    if (ld_scroll)
                    begin
                        p_a = su_a;
                        p_b = su_b;
                    end
                end
                else
                begin
                    p_a   = mk_op(OP_FILL, 1'b0, curpos, curpos, C_ONE, ch_reg ^ fb);
                    p_col = col_reg + CW'(1);
                end
            end
            F_SETC:
            begin
                p_a = mk_op(OP_FILL, 1'b0, pos, pos, C_ONE, ch_reg ^ fb);
            end
            F_PUTXY:
            begin
                if (in_xy)
                begin
                    p_a = mk_op(OP_FILL, 1'b0, xyb, xyb, C_ONE, ch_reg ^ fb);
                end
            end
            F_GOTO, F_SETX:
            begin
                if (colin_reg[7])
                begin
                    p_col = '0;
                end
                else if (colin_reg >= 8'(COLS))
                begin
                    p_col = CW'(COLS - 1);
                end
                else
                begin
                    p_col = CW'(colin_reg);
                end
                if (func_reg == F_GOTO)
                begin
                    if (rowin_reg[7])
                    begin
                        p_row = '0;
                    end
                    else if (rowin_reg >= 8'(ROWS))
                    begin
                        p_row = RW'(ROWS - 1);
                    end
                    else
                    begin
                        p_row = RW'(rowin_reg);
                    end
                end
            end
            F_MOVEX:
            begin
                if (sx < 10'sd0)
                begin
                    p_col = '0;
                end
                else if (sx > 10'(COLS - 1))
                begin
                    p_col = CW'(COLS - 1);
                end
                else
                begin
                    p_col = CW'(sx);
                end
            end
            F_MOVEY:
            begin
                if (sy < $signed(10'(top_reg)))
                begin
                    p_row = top_reg;
                end
                else if (sy > $signed(10'(bot_reg)))
                begin
                    p_row = bot_reg;
                end
                else
                begin
                    p_row = RW'(sy);
                end
            end
            F_SOL:
            begin
                p_col = '0;
            end
            F_CFWD:
            begin
                if (col_reg == CW'(COLS))
                begin
                    p_col = '0;
                    p_row = ld_row;
                    if (ld_scroll)
                    begin
                        p_a = su_a;
                        p_b = su_b;
                    end
                end
                else
                begin
                    p_col = col_reg + CW'(1);
                end
            end
            F_CBACK, F_LBACK:
            begin
                if (func_reg == F_CBACK && col_reg != '0)
                begin
                    p_col = col_reg - CW'(1);
                end
                else if (row_reg == '0)
                begin
                    p_col = '0;
                    p_row = top_reg;
                end
                else
                begin
                    p_col = CW'(COLS - 1);
                    p_row = row_reg - RW'(1);
                end
            end
            F_LF, F_LFWD:
            begin
                if (func_reg == F_LFWD)
                begin
                    p_col = '0;
                end
                p_row = ld_row;
                if (ld_scroll)
                begin
                    p_a = su_a;
                    p_b = su_b;
                end
            end
            F_SCROLL_UP:
            begin
                p_a = su_a;
                p_b = su_b;
            end
            F_SCROLL_DN:
            begin
                p_a = sd_a;
                p_b = sd_b;
            end
            F_INS_LINE:
            begin
                if (row_reg < bot_reg)
                begin
                    p_a = mk_op(OP_COPY, 1'b1, bbase - C_ONE, bbase + C_COLS - C_ONE,
                                bbase - base, 8'h00);
                end
                if (row_reg <= bot_reg)
                begin
                    p_b = mk_op(OP_FILL, 1'b0, base, base, C_COLS, fb);
                end
            end
            F_DEL_LINE:
            begin
                if (row_reg < bot_reg)
                begin
                    p_a = mk_op(OP_COPY, 1'b0, base + C_COLS, base, bbase - base, 8'h00);
                end
                if (row_reg <= bot_reg)
                begin
                    p_b = mk_op(OP_FILL, 1'b0, bbase, bbase, C_COLS, fb);
                end
            end
            F_INS_CHAR:
            begin
                p_a = mk_op(OP_COPY, 1'b1, base + C_COLS - C_TWO, base + C_COLS - C_ONE,
                            C_COLS - ecn - C_ONE, 8'h00);
                p_b = mk_op(OP_FILL, 1'b0, pos, pos, C_ONE, fb);
            end
            F_DEL_CHAR:
            begin
                p_a = mk_op(OP_COPY, 1'b0, pos + C_ONE, pos, C_COLS - ecn - C_ONE, 8'h00);
                p_b = mk_op(OP_FILL, 1'b0, base + C_COLS - C_ONE, base + C_COLS - C_ONE,
                            C_ONE, fb);
            end
            F_ERASE:
            begin
                case (mode_reg)
                    ERASE_TO_END:    p_a = mk_op(OP_FILL, 1'b0, pos, pos, C_CELLS - pos, fb);
                    ERASE_TO_CURSOR: p_a = mk_op(OP_FILL, 1'b0, C_ZERO, C_ZERO, pos + C_ONE, fb);
                    ERASE_ALL:       p_a = mk_op(OP_FILL, 1'b0, C_ZERO, C_ZERO, C_CELLS, fb);
                    default:         p_a = op_none;
                endcase
            end
            F_ERASE_LINE:
            begin
                case (mode_reg)
                    ERASE_TO_END:    p_a = mk_op(OP_FILL, 1'b0, pos, pos, C_COLS - ecn, fb);
                    ERASE_TO_CURSOR: p_a = mk_op(OP_FILL, 1'b0, base, base, ecn + C_ONE, fb);
                    ERASE_ALL:       p_a = mk_op(OP_FILL, 1'b0, base, base, C_COLS, fb);
                    default:         p_a = op_none;
                endcase
            end
            F_CLRSCR:
            begin
                p_a   = mk_op(OP_FILL, 1'b0, C_ZERO, C_ZERO, C_CELLS, fb);
                p_top = '0;
                p_bot = RW'(ROWS - 1);
                p_col = '0;
                p_row = '0;
            end
            F_CLRLINE:
            begin
                p_a   = mk_op(OP_FILL, 1'b0, base, base, C_COLS, fb);
                p_col = '0;
            end
            F_CLREOL:
            begin
                p_a = mk_op(OP_FILL, 1'b0, pos, pos, C_COLS - ecn, fb);
            end
            F_MARGINS:
            begin
                if (t_s >= b_s)
                begin
                    p_top = '0;
                    p_bot = RW'(ROWS - 1);
                    p_row = '0;
                end
                else
                begin
                    p_top = RW'(t_s);
                    p_bot = RW'(b_s);
                    p_row = RW'(t_s);
                end
                p_col = '0;
            end
            F_RESET_MARGINS:
            begin
                p_top = '0;
                p_bot = RW'(ROWS - 1);
                p_col = '0;
                p_row = '0;
            end
            F_REVERSE:
            begin
                p_rev  = en_reg;
                p_cont = CONT_DONE;
            end
            F_CURSOR:
            begin
                // Showing or hiding flips the mark once, unless a wrap is pending.
                if (en_reg != curs_reg)
                begin
                    p_curs = en_reg;
                    if (col_reg < CW'(COLS))
                    begin
                        p_a = xor_cur;
                    end
                end
                p_cont = CONT_DONE;
            end
            F_INVERT:
            begin
                if (in_xy)
                begin
                    p_a = mk_op(OP_XOR, 1'b0, xyb, xyb,
                                (LW'(len_reg) < LW'(rem)) ? CNTW'(len_reg) : rem, 8'h00);
                end
                p_cont = CONT_DONE;
            end
            F_READ:
            begin
                if (in_xy)
                begin
                    p_a = mk_op(OP_READ, 1'b0, xyb, xyb, C_ONE, 8'h00);
                end
                p_cont = CONT_DONE;
            end
            F_NOP:
            begin
                p_cont = CONT_DONE;
            end
            default:
            begin
                p_cont = CONT_DONE;
            end
        endcase
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_UNMARK;
                end
            end
            ST_UNMARK, ST_PLAN, ST_MARK:
            begin
                state_next = ST_DISPATCH;
            end
            ST_DISPATCH:
            begin
                if (op_live)
                begin
                    state_next = (op_reg.kind == OP_FILL) ? ST_RUN_WR : ST_RUN_RD;
                end
                else if (opb_reg.kind != OP_NONE)
                begin
                    state_next = ST_DISPATCH;
                end
                else
                begin
                    unique case (cont_reg)
                        CONT_PLAN: state_next = ST_PLAN;
                        CONT_MARK: state_next = ST_MARK;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_RUN_RD:
            begin
                state_next = ST_RUN_WR;
            end
            ST_RUN_WR:
            begin
                if (op_reg.cnt == C_ONE)
                begin
                    state_next = ST_DISPATCH;
                end
                else
                begin
                    state_next = (op_reg.kind == OP_FILL) ? ST_RUN_WR : ST_RUN_RD;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath updates and memory port controls.
    always_comb
    begin
        op_next   = op_reg;
        opb_next  = opb_reg;
        cont_next = cont_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        top_next  = top_reg;
        bot_next  = bot_reg;
        rev_next  = rev_reg;
        curs_next = curs_reg;
        rdc_next  = rdc_reg;
        clr_next  = clr_reg;
        ram_we    = 1'b0;
        ram_waddr = op_reg.dst;
        ram_wdata = op_reg.data;
        ram_raddr = op_reg.src;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 8'h00;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    rdc_next = 8'h00;
                end
            end
            ST_UNMARK:
            begin
                // Commands up to F_RESET_MARGINS lift the cursor mark, if it is visible, before they start.
                op_next   = (func_reg <= F_RESET_MARGINS && vis) ? xor_cur : op_none;
                opb_next  = op_none;
                cont_next = CONT_PLAN;
            end
            ST_PLAN:
            begin
                op_next   = p_a;
                opb_next  = p_b;
                cont_next = p_cont;
                col_next  = p_col;
                row_next  = p_row;
                top_next  = p_top;
                bot_next  = p_bot;
                rev_next  = p_rev;
                curs_next = p_curs;
            end
            ST_MARK:
            begin
                op_next   = vis ? xor_cur : op_none;
                cont_next = CONT_DONE;
            end
            ST_DISPATCH:
            begin
                if (!op_live && opb_reg.kind != OP_NONE)
                begin
                    op_next  = opb_reg;
                    opb_next = op_none;
                end
            end
            ST_RUN_RD:
            begin
                ram_raddr = op_reg.src;
            end
            ST_RUN_WR:
            begin
                case (op_reg.kind)
                    OP_COPY: ram_wdata = ram_rdata;
                    OP_XOR:  ram_wdata = ram_rdata ^ REV_BIT;
                    default: ram_wdata = op_reg.data;
                endcase
                ram_we = (op_reg.kind != OP_READ);
                if (op_reg.kind == OP_READ)
                begin
                    rdc_next = ram_rdata;
                end
                op_next.cnt = op_reg.cnt - C_ONE;
                op_next.src = op_reg.desc ? op_reg.src - AW'(1) : op_reg.src + AW'(1);
                op_next.dst = op_reg.desc ? op_reg.dst - AW'(1) : op_reg.dst + AW'(1);
                if (op_reg.cnt == C_ONE)
                begin
                    op_next.kind = OP_NONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            op_reg    <= '0;
            opb_reg   <= '0;
            cont_reg  <= CONT_DONE;
            col_reg   <= '0;
            row_reg   <= '0;
            top_reg   <= '0;
            bot_reg   <= RW'(ROWS - 1);
            rev_reg   <= 1'b0;
            curs_reg  <= 1'b0;
            rdc_reg   <= 8'h00;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            opb_reg   <= opb_next;
            cont_reg  <= cont_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            top_reg   <= top_next;
            bot_reg   <= bot_next;
            rev_reg   <= rev_next;
            curs_reg  <= curs_next;
            rdc_reg   <= rdc_next;
            clr_reg   <= clr_next;
        end
    end

    // The command beat is held until the next accepted command.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func_t'(func);
            ch_reg    <= char_code;
            colin_reg <= col;
            rowin_reg <= row;
            amt_reg   <= $signed(amount);
            len_reg   <= length;
            mode_reg  <= erase_mode;
            en_reg    <= enable;
            topin_reg <= top;
            botin_reg <= bottom;
        end
    end

    assign busy          = (state_reg != ST_IDLE);
    assign done          = (state_reg == ST_DONE);
    assign read_char     = rdc_reg;
    assign cursor_col    = 7'(col_reg);
    assign cursor_row    = 5'(row_reg);
    assign cursor_shown  = curs_reg;
    assign region_top    = 5'(top_reg);
    assign bottom_margin = 5'(bot_reg);
    assign reverse_shown = rev_reg;

endmodule

// File: sv/tte_checker.sv
`include "assert_macros.svh"

module tte_checker #(
    parameter int COLS = 64
) (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [6:0] cursor_col
);

    // A status beat only appears while a command is in flight.
    `ASSERT_SAME(a_done_busy, clk, rst_n, done, busy)
    // An accepted command makes the block busy on the next cycle.
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // Each status beat lasts exactly one cycle.
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // At each status beat, the reported column does not pass the pending-wrap column.
    `ASSERT_SAME(a_col_range, clk, rst_n, done, cursor_col <= 7'(COLS))

endmodule

bind text_terminal_cell_engine tte_checker #(.COLS(COLS)) u_tte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cursor_col(cursor_col)
);
